/* rtl/ccsoc_pkg.sv */
package ccsoc_pkg;

  // Build-time sizes
  localparam int ADC_BITS    = 10;
  localparam int CHARGE_BITS = 40;

  // Port and register widths
  localparam int ADC_IN_W  = 10;
  localparam int MS_W      = 16;
  localparam int THR_W     = 10;
  localparam int GAIN_W    = 20;
  localparam int CAP_W     = 40;
  localparam int CUR_OUT_W = 16;
  localparam int REM_OUT_W = 40;
  localparam int SOC_W     = 14;

  // Gain is unsigned Q8
  localparam int GAIN_FRAC = 8;
  localparam int CUR_W     = ADC_BITS + GAIN_W - GAIN_FRAC;

  localparam int SOC_FULL = 10000;

  // Shared adder width: covers the scaled charge product and the divide remainder
  localparam int WIDE_W = (CAP_W > CHARGE_BITS) ? CAP_W : CHARGE_BITS;
  localparam int ALU_W  = WIDE_W + 16;
  localparam int LOAD_W = WIDE_W;
  localparam int CMP_W  = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

  // Multiplier shift register, also dividend/quotient shifter during the divide
  localparam int MPLR_W = 16;
  localparam int CNT_W  = $clog2(MPLR_W + 1);

  // APB port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  // Register indexes
  localparam logic [1:0] REG_THR  = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;
  localparam logic [1:0] REG_CAP  = 2'd2;

  // Register reset values
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(4);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(11803);
  localparam logic [CAP_W-1:0]  CAP_RST  = CAP_W'(64'd32400000000);

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             carry;
    logic [ALU_W-1:0] res;
  } alu_rsp_t;

endpackage

/* rtl/ccsoc_alu.sv */
module ccsoc_alu import ccsoc_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   sum;

  // Add, or subtract by two's complement; carry out means a >= b on subtract
  assign b_op = req_i.b ^ {ALU_W{req_i.sub}};
  assign sum  = {1'b0, req_i.a} + {1'b0, b_op} + (ALU_W + 1)'(req_i.sub);

  assign rsp_o.carry = sum[ALU_W];
  assign rsp_o.res   = sum[ALU_W-1:0];

endmodule

/* rtl/coulomb_counter_soc.sv */
// Coulomb counter with state of charge. Each accepted sample (ADC code and
// elapsed milliseconds) is finished before the next sample is accepted: one
// shared adder does the current, used-charge and charge-times-10000 products
// by shift-and-add one multiplier bit per cycle, the saturating subtract, and
// the state-of-charge division by restoring division one quotient bit per cycle.
// A sample with zero elapsed time is accepted and gives no result.
// A finished result waits in an output register and does not block intake;
// while it waits, the next sample holds in its last cycle, and intake stays
// closed, until that result is taken.
// Writing the capacity register reloads the remaining charge; the user must
// write configuration only while the block is idle; the block does not enforce it.
module coulomb_counter_soc import ccsoc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ADC_IN_W-1:0]  adc_code_i,
  input  logic [MS_W-1:0]      elapsed_ms_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CUR_OUT_W-1:0] current_ma_o,
  output logic [REM_OUT_W-1:0] remaining_uas_o,
  output logic [SOC_W-1:0]     soc_centipercent_o,
  output logic                 depleted_o,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MUL_CUR  = 7'b0000010,
    S_MUL_USED = 7'b0000100,
    S_SUB      = 7'b0001000,
    S_MUL_SOC  = 7'b0010000,
    S_DIV      = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  function automatic logic [CHARGE_BITS-1:0] load_charge(input logic [CAP_W-1:0] cap);
    logic [LOAD_W-1:0] capx;
    logic [LOAD_W-1:0] maxx;
    capx = LOAD_W'(cap);
    maxx = LOAD_W'({CHARGE_BITS{1'b1}});
    if (capx > maxx) begin
      return {CHARGE_BITS{1'b1}};
    end
    return CHARGE_BITS'(capx);
  endfunction

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [ALU_W-1:0]       acc_q, acc_d;
  logic [ALU_W-1:0]       mcand_q, mcand_d;
  logic [MPLR_W-1:0]      mplier_q, mplier_d;
  logic [MS_W-1:0]        ms_q, ms_d;
  logic [CUR_W-1:0]       cur_q, cur_d;
  logic [CHARGE_BITS-1:0] rem_q, rem_d;

  logic [THR_W-1:0]       thr_q;
  logic [GAIN_W-1:0]      gain_q;
  logic [CAP_W-1:0]       cap_q;

  logic                   out_valid_q, out_valid_d;
  logic [CUR_OUT_W-1:0]   cur_out_q, cur_out_d;
  logic [REM_OUT_W-1:0]   rem_out_q, rem_out_d;
  logic [SOC_W-1:0]       soc_out_q, soc_out_d;
  logic                   depl_out_q, depl_out_d;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  logic                   in_fire;
  logic                   cfg_wr;
  logic [1:0]             cfg_idx;
  logic [ADC_BITS-1:0]    code;
  logic                   below_thr;
  logic [CAP_W:0]         div_t;
  logic [CUR_W-1:0]       cur_new;
  logic [CHARGE_BITS-1:0] rem_new;
  logic [SOC_W-1:0]       quot;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = paddr[PADDR_W-1:3];
  assign pready     = 1'b1;

  assign code      = ADC_BITS'(adc_code_i);
  assign below_thr = CMP_W'(code) < CMP_W'(thr_q);
  assign div_t     = {mcand_q[CAP_W-1:0], mplier_q[MPLR_W-1]};
  assign cur_new   = alu_rsp.res[GAIN_FRAC +: CUR_W];
  assign rem_new   = alu_rsp.carry ? alu_rsp.res[CHARGE_BITS-1:0] : '0;
  assign quot      = mplier_q[SOC_W-1:0];

  ccsoc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // Select operands for the shared adder
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      S_MUL_CUR, S_MUL_USED, S_MUL_SOC: begin
        alu_req.a = acc_q;
        alu_req.b = mplier_q[0] ? mcand_q : '0;
      end
      S_SUB: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(rem_q);
        alu_req.b   = acc_q;
      end
      S_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(div_t);
        alu_req.b   = ALU_W'(cap_q);
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // Sequence one sample through multiply, subtract and divide
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    ms_d        = ms_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cur_out_d   = cur_out_q;
    rem_out_d   = rem_out_q;
    soc_out_d   = soc_out_q;
    depl_out_d  = depl_out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (elapsed_ms_i != '0)) begin
          acc_d    = '0;
          mcand_d  = ALU_W'(gain_q);
          mplier_d = below_thr ? '0 : MPLR_W'(code);
          ms_d     = elapsed_ms_i;
          cnt_d    = CNT_W'(ADC_BITS - 1);
          state_d  = S_MUL_CUR;
        end
      end
      S_MUL_CUR: begin
        acc_d    = alu_rsp.res;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cur_d    = cur_new;
          acc_d    = '0;
          mcand_d  = ALU_W'(cur_new);
          mplier_d = MPLR_W'(ms_q);
          cnt_d    = CNT_W'(MS_W - 1);
          state_d  = S_MUL_USED;
        end
      end
      S_MUL_USED: begin
        acc_d    = alu_rsp.res;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_SUB;
        end
      end
      S_SUB: begin
        rem_d    = rem_new;
        acc_d    = '0;
        mcand_d  = ALU_W'(rem_new);
        mplier_d = MPLR_W'(SOC_FULL);
        cnt_d    = CNT_W'(SOC_W - 1);
        state_d  = S_MUL_SOC;
      end
      S_MUL_SOC: begin
        acc_d    = alu_rsp.res;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          // seed the remainder with the high dividend bits, queue the low ones
          mcand_d  = ALU_W'(alu_rsp.res[SOC_W +: CAP_W]);
          mplier_d = MPLR_W'(alu_rsp.res[SOC_W-1:0]) << (MPLR_W - SOC_W);
          cnt_d    = CNT_W'(SOC_W - 1);
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        mcand_d  = alu_rsp.carry ? ALU_W'(alu_rsp.res[CAP_W:0]) : ALU_W'(div_t);
        mplier_d = {mplier_q[MPLR_W-2:0], alu_rsp.carry};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          cur_out_d   = (cur_q > CUR_W'({CUR_OUT_W{1'b1}})) ?
                        {CUR_OUT_W{1'b1}} : cur_q[CUR_OUT_W-1:0];
          rem_out_d   = REM_OUT_W'(rem_q);
          if (cap_q == '0) begin
            soc_out_d = '0;
          end else if (quot > SOC_W'(SOC_FULL)) begin
            soc_out_d = SOC_W'(SOC_FULL);
          end else begin
            soc_out_d = quot;
          end
          depl_out_d  = (rem_q == '0);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Reload remaining charge on a capacity write
    if (cfg_wr && (cfg_idx == REG_CAP)) begin
      rem_d = load_charge(pwdata[CAP_W-1:0]);
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rem_q       <= load_charge(CAP_RST);
      thr_q       <= THR_RST;
      gain_q      <= GAIN_RST;
      cap_q       <= CAP_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_THR:  thr_q  <= pwdata[THR_W-1:0];
          REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
          REG_CAP:  cap_q  <= pwdata[CAP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplier_q   <= mplier_d;
    ms_q       <= ms_d;
    cur_q      <= cur_d;
    cur_out_q  <= cur_out_d;
    rem_out_q  <= rem_out_d;
    soc_out_q  <= soc_out_d;
    depl_out_q <= depl_out_d;
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_THR:  prdata = PDATA_W'(thr_q);
      REG_GAIN: prdata = PDATA_W'(gain_q);
      REG_CAP:  prdata = PDATA_W'(cap_q);
      default:  prdata = '0;
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign current_ma_o       = cur_out_q;
  assign remaining_uas_o    = rem_out_q;
  assign soc_centipercent_o = soc_out_q;
  assign depleted_o         = depl_out_q;

endmodule

/* rtl/ccsoc_checker.sv */
module ccsoc_checker import ccsoc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [MS_W-1:0]      elapsed_ms_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [CUR_OUT_W-1:0] current_ma_o,
  input logic [REM_OUT_W-1:0] remaining_uas_o,
  input logic [SOC_W-1:0]     soc_centipercent_o,
  input logic                 depleted_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(current_ma_o) &&
    $stable(remaining_uas_o) && $stable(soc_centipercent_o) && $stable(depleted_o))
    else $error("result changed while stalled");

  // State of charge never exceeds full
  a_soc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> soc_centipercent_o <= SOC_W'(SOC_FULL))
    else $error("state of charge above full");

  // Depleted flag matches an empty remaining charge
  a_depleted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> depleted_o == (remaining_uas_o == '0))
    else $error("depleted flag disagrees with remaining charge");

  // A sample with time elapsed keeps the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (elapsed_ms_i != '0) |=> !in_ready_o)
    else $error("sample intake not blocked during computation");

  // A zero-interval sample produces no result
  a_zero_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (elapsed_ms_i == '0) && !out_valid_o |=> !out_valid_o)
    else $error("result produced for zero interval");

endmodule

bind coulomb_counter_soc ccsoc_checker u_ccsoc_checker (.*);
